@@ design/cst_pkg.sv @@
`timescale 1ns / 1ps

package cst_pkg;

  typedef enum logic [4:0] {
    TK_EOF        = 5'd0,
    TK_UNEXPECTED = 5'd1,
    TK_EOL        = 5'd3,
    TK_COMMENT    = 5'd4,
    TK_IDENT      = 5'd5,
    TK_INT        = 5'd6,
    TK_FLOAT      = 5'd7,
    TK_PLUS       = 5'd8,
    TK_MINUS      = 5'd9,
    TK_STAR       = 5'd10,
    TK_SLASH      = 5'd11,
    TK_EQUAL      = 5'd12,
    TK_LPAREN     = 5'd13,
    TK_RPAREN     = 5'd14,
    TK_LBRACE     = 5'd15,
    TK_RBRACE     = 5'd16,
    TK_LBRACK     = 5'd17,
    TK_RBRACK     = 5'd18
  } tok_kind_e;

  localparam int unsigned MaxTokens = 3;

  typedef struct packed {
    tok_kind_e   kind;
    logic [15:0] start_col;
    logic [15:0] end_col;
  } tok_t;

  // tokens finished by one byte, slot 0 first
  typedef struct packed {
    logic [1:0]                 count;
    logic [15:0]                line;
    tok_t [MaxTokens-1:0]       toks;
  } bundle_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

@@ design/cst_if.sv @@
`timescale 1ns / 1ps

interface cst_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface cst_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] start_column;
  logic [15:0] end_column;
  logic [15:0] line_number;
  logic        last_of_run;

  modport source (
    output valid, output token_kind, output start_column, output end_column,
    output line_number, output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input start_column, input end_column,
    input line_number, input last_of_run, output ready
  );
endinterface

@@ design/cst_front.sv @@
`timescale 1ns / 1ps

module cst_front #(
  parameter int unsigned P = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cst_char_if.sink         char_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output cst_pkg::bundle_t push_data_o
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_IDENT,
    M_INT,
    M_INT_DOT,
    M_FLOAT,
    M_SLASH,
    M_COMMENT
  } mode_e;

  mode_e          mode_q, mode_d;
  logic [P-1:0]   ts_q, ts_d;
  logic [P-1:0]   col_q, col_d;
  logic [P-1:0]   line_q, line_d;
  logic [1:0]     n;
  logic           go_idle;
  logic           accept;
  logic [7:0]     c;
  logic           is_let, is_dig;
  cst_pkg::bundle_t bund;

  function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
    return (&v) ? v : v + P'(1);
  endfunction

  function automatic cst_pkg::tok_t mk_tok(input cst_pkg::tok_kind_e k,
                                           input logic [P-1:0] s,
                                           input logic [P-1:0] e);
    cst_pkg::tok_t t;
    t.kind      = k;
    t.start_col = 16'(s);
    t.end_col   = 16'(e);
    return t;
  endfunction

  function automatic cst_pkg::tok_kind_e punct_kind(input logic [7:0] ch);
    cst_pkg::tok_kind_e k;
    unique case (ch)
      8'h2B:   k = cst_pkg::TK_PLUS;
      8'h2D:   k = cst_pkg::TK_MINUS;
      8'h2A:   k = cst_pkg::TK_STAR;
      8'h3D:   k = cst_pkg::TK_EQUAL;
      8'h28:   k = cst_pkg::TK_LPAREN;
      8'h29:   k = cst_pkg::TK_RPAREN;
      8'h7B:   k = cst_pkg::TK_LBRACE;
      8'h7D:   k = cst_pkg::TK_RBRACE;
      8'h5B:   k = cst_pkg::TK_LBRACK;
      8'h5D:   k = cst_pkg::TK_RBRACK;
      default: k = cst_pkg::TK_UNEXPECTED;
    endcase
    return k;
  endfunction

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChNul   = 8'h00;

  assign c      = char_i.char_code;
  assign is_let = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_dig = (c >= 8'h30 && c <= 8'h39);

  always_comb begin
    mode_d    = mode_q;
    ts_d      = ts_q;
    col_d     = col_q;
    line_d    = line_q;
    n         = 2'd0;
    go_idle   = 1'b0;
    bund      = '0;
    bund.line = 16'(line_q);

    // settle the token in progress
    unique case (mode_q)
      M_IDENT: begin
        if (is_let) begin
          col_d = sat_inc(col_q);
        end else begin
          bund.toks[n] = mk_tok(cst_pkg::TK_IDENT, ts_q, col_q);
          n = n + 2'd1;
          go_idle = 1'b1;
        end
      end
      M_INT: begin
        if (is_dig) begin
          col_d = sat_inc(col_q);
        end else if (c == ChDot) begin
          mode_d = M_INT_DOT;
        end else begin
          bund.toks[n] = mk_tok(cst_pkg::TK_INT, ts_q, col_q);
          n = n + 2'd1;
          go_idle = 1'b1;
        end
      end
      M_INT_DOT: begin
        if (is_dig) begin
          col_d  = sat_inc(sat_inc(col_q));
          mode_d = M_FLOAT;
        end else begin
          bund.toks[n] = mk_tok(cst_pkg::TK_INT, ts_q, col_q);
          n = n + 2'd1;
          bund.toks[n] = mk_tok(cst_pkg::TK_UNEXPECTED, col_q, sat_inc(col_q));
          n = n + 2'd1;
          col_d = sat_inc(col_q);
          go_idle = 1'b1;
        end
      end
      M_FLOAT: begin
        if (is_dig) begin
          col_d = sat_inc(col_q);
        end else begin
          bund.toks[n] = mk_tok(cst_pkg::TK_FLOAT, ts_q, col_q);
          n = n + 2'd1;
          go_idle = 1'b1;
        end
      end
      M_SLASH: begin
        if (c == ChSlash) begin
          col_d  = sat_inc(col_q);
          mode_d = M_COMMENT;
        end else begin
          bund.toks[n] = mk_tok(cst_pkg::TK_SLASH, ts_q, sat_inc(ts_q));
          n = n + 2'd1;
          go_idle = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == ChNl || c == ChNul) begin
          bund.toks[n] = mk_tok(cst_pkg::TK_COMMENT, ts_q, col_q);
          n = n + 2'd1;
          go_idle = 1'b1;
        end else begin
          col_d = sat_inc(col_q);
        end
      end
      default: go_idle = 1'b1;
    endcase

    // handle the byte from idle
    if (go_idle) begin
      mode_d = M_IDLE;
      priority if (is_let) begin
        ts_d   = col_d;
        col_d  = sat_inc(col_d);
        mode_d = M_IDENT;
      end else if (is_dig) begin
        ts_d   = col_d;
        col_d  = sat_inc(col_d);
        mode_d = M_INT;
      end else if (c == ChSpace) begin
        col_d = sat_inc(col_d);
      end else if (c == ChSlash) begin
        ts_d   = col_d;
        col_d  = sat_inc(col_d);
        mode_d = M_SLASH;
      end else if (c == ChNl) begin
        bund.toks[n] = mk_tok(cst_pkg::TK_EOL, col_d, sat_inc(col_d));
        n = n + 2'd1;
        col_d  = '0;
        line_d = sat_inc(line_q);
      end else if (c == ChNul) begin
        bund.toks[n] = mk_tok(cst_pkg::TK_EOF, col_d, sat_inc(col_d));
        n = n + 2'd1;
        ts_d   = '0;
        col_d  = '0;
        line_d = '0;
      end else begin
        bund.toks[n] = mk_tok(punct_kind(c), col_d, sat_inc(col_d));
        n = n + 2'd1;
        col_d = sat_inc(col_d);
      end
    end
    bund.count = n;
  end

  assign char_i.ready = push_ready_i;
  assign accept       = char_i.valid && push_ready_i;
  assign push_valid_o = accept && (n != 2'd0);
  assign push_data_o  = bund;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      ts_q   <= '0;
      col_q  <= '0;
      line_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      ts_q   <= ts_d;
      col_q  <= col_d;
      line_q <= line_d;
    end
  end

endmodule

@@ design/cst_queue.sv @@
`timescale 1ns / 1ps

module cst_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  cst_pkg::bundle_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output cst_pkg::bundle_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cst_pkg::bundle_t mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= nxt(wr_q);
      end
      if (do_pop) begin
        rd_q <= nxt(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ design/cst_back.sv @@
`timescale 1ns / 1ps

module cst_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_o,
  input  cst_pkg::bundle_t pop_data_i,
  cst_token_if.source      tok_o
);

  logic [1:0]    idx_q;
  logic          out_valid_q;
  logic          load;
  logic          last;
  cst_pkg::tok_t cur;
  cst_pkg::tok_t tok_q;
  logic [15:0]   line_q;
  logic          last_q;

  assign load  = pop_valid_i && (!out_valid_q || tok_o.ready);
  assign cur   = pop_data_i.toks[idx_q];
  assign last  = (idx_q == pop_data_i.count - 2'd1);
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? 2'd0 : idx_q + 2'd1;
      end else if (tok_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= cur;
      line_q <= pop_data_i.line;
      last_q <= last;
    end
  end

  assign tok_o.valid        = out_valid_q;
  assign tok_o.token_kind   = tok_q.kind;
  assign tok_o.start_column = tok_q.start_col;
  assign tok_o.end_column   = tok_q.end_col;
  assign tok_o.line_number  = line_q;
  assign tok_o.last_of_run  = last_q;

endmodule

@@ design/char_stream_tokenizer.sv @@
`timescale 1ns / 1ps

// port     dir  transfer   payload
// char_i   in   valid&rdy  char_code[7:0]
// tok_o    out  valid&rdy  token_kind, start_column, end_column, line_number, last_of_run
//
// One byte is taken per cycle while the bundle queue is not full.
// A byte that finishes two or three tokens holds its bundle in the queue until
// all are sent, since the output stage sends one token per cycle when not stalled.
// The input stalls only when the bundle queue is full.
// Reset clears the scanner, queue pointers and output valid; no sweep.
// Back pressure on tok_o holds the output register and fills the queue.

module char_stream_tokenizer #(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned QUEUE_DEPTH   = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cst_char_if.sink    char_i,
  cst_token_if.source tok_o
);

  logic             push_valid, push_ready;
  logic             pop_valid, pop;
  cst_pkg::bundle_t push_data, pop_data;

  cst_front #(
    .P (POSITION_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_i       (char_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  cst_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  cst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .tok_o       (tok_o)
  );

endmodule
